// File: rtl/h2j_pkg.sv
// Package for the heliocentric to Jacobi converter: widths and constants.
// Used by every module in rtl/.
package h2j_pkg;
    localparam int COORD_WIDTH = 48;
    localparam int MASS_WIDTH  = 48;
    localparam int SUM_WIDTH   = 64;
    localparam int FIX_SHIFT   = 32;
    localparam int N_AXES      = 6;
endpackage

// File: rtl/h2j_serial_div.sv
// Bit-serial restoring divider: (|sum| << 32) / mass, one quotient bit a cycle.
// Depends on h2j_pkg.
module h2j_serial_div #(
    parameter int MW = h2j_pkg::MASS_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [h2j_pkg::SUM_WIDTH-1:0] i_smag,
    input  logic [MW-1:0]                 i_mass,
    output logic                          o_done,
    output logic [h2j_pkg::SUM_WIDTH-1:0] o_quot,
    output logic                          o_huge
);
    import h2j_pkg::*;
    localparam int NB = SUM_WIDTH + FIX_SHIFT;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0]      r_num;
    logic [SUM_WIDTH:0] r_rem;
    logic [NB-1:0]      r_q;
    logic [CW-1:0]      r_cnt;
    logic               r_busy;
    logic [SUM_WIDTH:0] n_rem;
    logic [SUM_WIDTH:0] n_dif;

    always_comb begin
        n_rem = {r_rem[SUM_WIDTH-1:0], r_num[NB-1]};
        n_dif = n_rem - {{(SUM_WIDTH+1-MW){1'b0}}, i_mass};
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_num  <= {i_smag, {FIX_SHIFT{1'b0}}};
            r_rem  <= '0;
            r_q    <= '0;
            r_cnt  <= CW'(NB);
        end else if (r_busy) begin
            r_num <= {r_num[NB-2:0], 1'b0};
            if (!n_dif[SUM_WIDTH]) begin
                r_rem <= n_dif;
                r_q   <= {r_q[NB-2:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_q   <= {r_q[NB-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    assign o_quot = r_q[SUM_WIDTH-1:0];
    assign o_huge = |r_q[NB-1:SUM_WIDTH];
endmodule

// File: rtl/h2j_serial_mul.sv
// Bit-serial shift-add multiplier: mass times coordinate magnitude.
// Depends on h2j_pkg.
module h2j_serial_mul #(
    parameter int MW = h2j_pkg::MASS_WIDTH,
    parameter int CWD = h2j_pkg::COORD_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MW-1:0]     i_mass,
    input  logic [CWD-1:0]    i_mag,
    output logic              o_done,
    output logic [MW+CWD-1:0] o_prod
);
    import h2j_pkg::*;
    localparam int KW = $clog2(CWD + 1);

    logic [MW+CWD-1:0] r_acc;
    logic [CWD-1:0]    r_b;
    logic [MW-1:0]     r_a;
    logic [KW-1:0]     r_cnt;
    logic              r_busy;
    logic [MW:0]       n_top;

    assign n_top = {1'b0, r_acc[MW+CWD-1:CWD]} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_acc  <= '0;
            r_a    <= i_mass;
            r_b    <= i_mag;
            r_cnt  <= KW'(CWD);
        end else if (r_busy) begin
            r_acc <= {n_top, r_acc[CWD-1:1]};
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == KW'(1)) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    assign o_prod = r_acc;
endmodule

// File: rtl/heliocentric_to_jacobi.sv
// Channel  | dir | contents
// s_axis   | in  | tuser=first_body, tdata=mass,px,py,pz,vx,vy,vz
// m_axis   | out | tuser=fault, tdata=jpx,jpy,jpz,jvx,jvy,jvz
// One body at a time. A central body sets the total mass to its own and gives a zero
// result. For any other body, per axis: a 96-bit serial divide, a combine, a 48-bit serial
// multiply and an accumulate (the divide is not waited for if the earlier mass is 0).
// Synchronous active-low reset clears mass and sums.
// The result register holds while m_axis_tready is low; input waits.
// Depends on h2j_pkg, h2j_serial_div, h2j_serial_mul.
module heliocentric_to_jacobi #(
    parameter int COORD_WIDTH = h2j_pkg::COORD_WIDTH,
    parameter int MASS_WIDTH  = h2j_pkg::MASS_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // body_mass, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic [((MASS_WIDTH+6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // first_body
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // jac_pos_x, jac_pos_y, jac_pos_z, jac_vel_x, jac_vel_y, jac_vel_z
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // fault
    output logic m_axis_tuser
);
    import h2j_pkg::*;
    localparam int CW = COORD_WIDTH;
    localparam int MW = MASS_WIDTH;
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_JAC = 3'd2,
                           S_MUL = 3'd3, S_ACC = 3'd4, S_MASS = 3'd5, S_OUT = 3'd6;

    logic [2:0]           r_state;
    logic [MW-1:0]        r_total;
    logic [SUM_WIDTH-1:0] r_sum [N_AXES];
    logic [MW-1:0]        r_mass;
    logic [CW-1:0]        r_h [N_AXES];
    logic [CW-1:0]        r_j [N_AXES];
    logic [2:0]           r_ax;
    logic                 r_fault;
    logic                 r_ovalid;
    logic                 r_start;

    logic [CW-1:0]        w_h;
    logic [SUM_WIDTH-1:0] w_sum;
    logic                 w_hn, w_sn;
    logic [CW-1:0]        w_hm;
    logic [SUM_WIDTH-1:0] w_smag;
    logic                 div_done, div_huge, mul_done;
    logic [SUM_WIDTH-1:0] div_q;
    logic [MW+CW-1:0]     mul_p;

    assign w_h    = r_h[r_ax];
    assign w_sum  = r_sum[r_ax];
    assign w_hn   = w_h[CW-1];
    assign w_hm   = w_hn ? (CW'(0) - w_h) : w_h;
    assign w_sn   = w_sum[SUM_WIDTH-1];
    assign w_smag = w_sn ? (SUM_WIDTH'(0) - w_sum) : w_sum;

    h2j_serial_div #(.MW(MW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_start && r_state == S_DIV),
        .i_smag(w_smag), .i_mass(r_total),
        .o_done(div_done), .o_quot(div_q), .o_huge(div_huge)
    );

    h2j_serial_mul #(.MW(MW), .CWD(CW)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_start && r_state == S_MUL),
        .i_mass(r_mass), .i_mag(w_hm),
        .o_done(mul_done), .o_prod(mul_p)
    );

    // Jacobi combine
    logic [SUM_WIDTH-1:0] cm, hm64, rm, lim;
    logic                 cn, rn, over, jfault;
    logic [SUM_WIDTH:0]   addv;
    always_comb begin
        cn   = w_sn;
        cm   = (r_total == '0) ? '0 : div_q;
        hm64 = SUM_WIDTH'(w_hm);
        addv = {1'b0, hm64} + {1'b0, cm};
        over = 1'b0;
        rn   = w_hn;
        rm   = hm64;
        if (r_total != '0 && div_huge) begin
            rn = !cn; rm = '0; over = 1'b1;
        end else if (cm == '0) begin
            rn = w_hn; rm = hm64;
        end else if (w_hn == !cn) begin
            rm = addv[SUM_WIDTH-1:0]; over = addv[SUM_WIDTH]; rn = w_hn;
        end else if (hm64 >= cm) begin
            rm = hm64 - cm; rn = w_hn;
        end else begin
            rm = cm - hm64; rn = !cn;
        end
        lim = SUM_WIDTH'(1) << (CW - 1);
        if (!rn) lim = lim - 1'b1;
        jfault = over || rm > lim;
        if (jfault) rm = lim;
    end

    // Weigh and accumulate
    localparam int PW = MW + CW;
    logic [PW-1:0]        psh;
    logic [SUM_WIDTH-1:0] m64, wlim, wv, sres;
    logic                 whi, wfault, afault;
    always_comb begin
        psh  = mul_p >> FIX_SHIFT;
        m64  = (PW - FIX_SHIFT > SUM_WIDTH) ? psh[SUM_WIDTH-1:0] : SUM_WIDTH'(psh);
        whi  = (PW - FIX_SHIFT > SUM_WIDTH) ? |(psh >> SUM_WIDTH) : 1'b0;
        wlim = w_hn ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        wfault = whi || m64 > wlim;
        if (wfault) m64 = wlim;
        wv   = w_hn ? (SUM_WIDTH'(0) - m64) : m64;
        sres = w_sum + wv;
        afault = (w_sum[SUM_WIDTH-1] == wv[SUM_WIDTH-1]) &&
                 (sres[SUM_WIDTH-1] != w_sum[SUM_WIDTH-1]);
        if (afault)
            sres = w_sum[SUM_WIDTH-1] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                      : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end

    logic [MW:0] tsum;
    assign tsum = {1'b0, r_total} + {1'b0, r_mass};

    always_ff @(posedge i_clk) begin
        r_start <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_ovalid <= 1'b0;
            r_ax     <= '0;
            for (int i = 0; i < N_AXES; i++) r_sum[i] <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mass <= s_axis_tdata[MW-1:0];
                        for (int i = 0; i < N_AXES; i++)
                            r_h[i] <= s_axis_tdata[MW+i*CW +: CW];
                        r_ax <= '0;
                        if (s_axis_tuser) begin
                            r_total <= s_axis_tdata[MW-1:0];
                            for (int i = 0; i < N_AXES; i++) begin
                                r_sum[i] <= '0;
                                r_j[i]   <= '0;
                            end
                            r_fault  <= 1'b0;
                            r_ovalid <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_fault <= (r_total == '0);
                            r_start <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: if ((div_done && !r_start) || (!r_start && r_total == '0))
                    r_state <= S_JAC;
                S_JAC: begin
                    r_j[r_ax] <= rn ? CW'(SUM_WIDTH'(0) - rm) : CW'(rm);
                    if (jfault) r_fault <= 1'b1;
                    r_start <= 1'b1;
                    r_state <= S_MUL;
                end
                S_MUL: if (mul_done) r_state <= S_ACC;
                S_ACC: begin
                    r_sum[r_ax] <= sres;
                    if (wfault || afault) r_fault <= 1'b1;
                    if (r_ax == 3'(N_AXES - 1)) begin
                        r_state <= S_MASS;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_start <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_MASS: begin
                    if (tsum[MW]) begin
                        r_total <= '1;
                        r_fault <= 1'b1;
                    end else begin
                        r_total <= tsum[MW-1:0];
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_fault;
    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < N_AXES; i++) m_axis_tdata[i*CW +: CW] = r_j[i];
    end
endmodule

// File: bench/tb_heliocentric_to_jacobi.sv
// Testbench for heliocentric_to_jacobi: drives bodies on s_axis, predicts Jacobi
// coordinates and the fault flag in fixed point, and checks every m_axis transaction.
// Depends on h2j_pkg and the heliocentric_to_jacobi RTL.
`timescale 1ns / 1ps

module tb_heliocentric_to_jacobi;
    import h2j_pkg::*;

    localparam int DW_IN  = ((MASS_WIDTH + 6 * COORD_WIDTH + 7) / 8) * 8;
    localparam int DW_OUT = ((6 * COORD_WIDTH + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] vz, vy, vx, pz, py, px;
        logic [MASS_WIDTH-1:0]  mass;
    } body_t;

    typedef struct {
        logic [COORD_WIDTH-1:0] coord [N_AXES];
        logic                   fault;
    } jacobi_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW_IN-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DW_OUT-1:0] m_axis_tdata;
    logic m_axis_tuser;

    heliocentric_to_jacobi i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [MASS_WIDTH-1:0] mass_total = '0;
    logic [SUM_WIDTH-1:0]  moment [N_AXES] = '{default: '0};
    jacobi_t expected_q [$];
    int  errors = 0;
    int  idle_cycles = 0;
    int  out_stall = 0;
    bit  stall_enable = 1'b1;
    string coord_name [N_AXES] = '{"jac_pos_x", "jac_pos_y", "jac_pos_z",
                                   "jac_vel_x", "jac_vel_y", "jac_vel_z"};

    localparam logic [COORD_WIDTH-1:0] CMASK = {COORD_WIDTH{1'b1}};

    function automatic logic [SUM_WIDTH-1:0] sat_add(logic [SUM_WIDTH-1:0] a,
            logic [SUM_WIDTH-1:0] b, inout logic flt);
        logic [SUM_WIDTH-1:0] r;
        r = a + b;
        if (a[SUM_WIDTH-1] == b[SUM_WIDTH-1] && r[SUM_WIDTH-1] != a[SUM_WIDTH-1]) begin
            flt = 1'b1;
            r = a[SUM_WIDTH-1] ? {1'b1, {SUM_WIDTH-1{1'b0}}} : {1'b0, {SUM_WIDTH-1{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] jacobi_coord(logic [COORD_WIDTH-1:0] h,
            logic [SUM_WIDTH-1:0] s, inout logic flt);
        logic hn, cn, rn, over;
        logic [63:0] hm, cm, rm, lim, smag;
        logic [127:0] quo;
        hn = h[COORD_WIDTH-1];
        hm = hn ? 64'((-h) & CMASK) : 64'(h);
        cn = s[SUM_WIDTH-1];
        cm = 0;
        over = 1'b0;
        if (mass_total != 0) begin
            smag = cn ? -s : s;
            quo = ({64'd0, smag} << FIX_SHIFT) / 128'(mass_total);
            cm = quo[63:0];
            if (quo[127:64] != 0) over = 1'b1;
        end
        if (over) begin
            rn = !cn; rm = 0;
        end else if (cm == 0) begin
            rn = hn; rm = hm;
        end else if (hn != cn) begin
            rm = hm + cm; over = rm < hm; rn = hn;
        end else if (hm >= cm) begin
            rm = hm - cm; rn = hn;
        end else begin
            rm = cm - hm; rn = !cn;
        end
        lim = 64'd1 << (COORD_WIDTH - 1);
        if (!rn) lim = lim - 1;
        if (over || rm > lim) begin
            rm = lim; flt = 1'b1;
        end
        return COORD_WIDTH'(rn ? -rm : rm);
    endfunction

    function automatic logic [SUM_WIDTH-1:0] mass_moment(logic [MASS_WIDTH-1:0] m,
            logic [COORD_WIDTH-1:0] h, inout logic flt);
        logic hn;
        logic [63:0] hm, lim;
        logic [127:0] p;
        hn = h[COORD_WIDTH-1];
        hm = hn ? 64'((-h) & CMASK) : 64'(h);
        p = (128'(m) * 128'(hm)) >> FIX_SHIFT;
        lim = hn ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (p[127:64] != 0 || p[63:0] > lim) begin
            p = 128'(lim); flt = 1'b1;
        end
        return hn ? -p[63:0] : p[63:0];
    endfunction

    function automatic jacobi_t convert_body(logic first, body_t b);
        jacobi_t r;
        logic flt;
        logic [COORD_WIDTH-1:0] h [N_AXES];
        logic [MASS_WIDTH:0] t;
        h = '{b.px, b.py, b.pz, b.vx, b.vy, b.vz};
        flt = 1'b0;
        if (first) begin
            for (int i = 0; i < N_AXES; i++) begin
                r.coord[i] = '0; moment[i] = '0;
            end
            r.fault = 1'b0;
            mass_total = b.mass;
            return r;
        end
        if (mass_total == 0) flt = 1'b1;
        for (int i = 0; i < N_AXES; i++) r.coord[i] = jacobi_coord(h[i], moment[i], flt);
        for (int i = 0; i < N_AXES; i++)
            moment[i] = sat_add(moment[i], mass_moment(b.mass, h[i], flt), flt);
        t = mass_total + b.mass;
        if (t[MASS_WIDTH]) begin
            t = {1'b0, {MASS_WIDTH{1'b1}}}; flt = 1'b1;
        end
        mass_total = t[MASS_WIDTH-1:0];
        r.fault = flt;
        return r;
    endfunction

    task automatic send_body(logic first, body_t b);
        @(posedge i_clk);
        if (stall_enable && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        expected_q.push_back(convert_body(first, b));
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= first;
        s_axis_tdata  <= DW_IN'(b);
        do @(posedge i_clk); while (!s_axis_tready);
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [COORD_WIDTH-1:0] rand_coord(int mode);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case (mode)
            0: return COORD_WIDTH'(v);
            1: return COORD_WIDTH'($signed(v[39:0]));
            default: return COORD_WIDTH'($signed(v[31:0]));
        endcase
    endfunction

    function automatic body_t rand_body(int mode);
        body_t b;
        logic [63:0] v;
        v = {$urandom, $urandom};
        b.mass = (mode == 0) ? MASS_WIDTH'(v) : MASS_WIDTH'(v[45:0]);
        if ($urandom_range(0, 19) == 0) b.mass = '0;
        b.px = rand_coord(mode); b.py = rand_coord(mode); b.pz = rand_coord(mode);
        b.vx = rand_coord(mode); b.vy = rand_coord(mode); b.vz = rand_coord(mode);
        return b;
    endfunction

    always @(posedge i_clk) begin
        jacobi_t e;
        logic [COORD_WIDTH-1:0] got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = expected_q.pop_front();
                for (int i = 0; i < N_AXES; i++) begin
                    got = m_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
                    if (got !== e.coord[i]) begin
                        $error("%s: expected %h actual %h", coord_name[i], e.coord[i], got);
                        errors++;
                    end
                end
                if (m_axis_tuser !== e.fault) begin
                    $error("fault: expected %0b actual %0b", e.fault, m_axis_tuser);
                    errors++;
                end
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (out_stall > 0) begin
            m_axis_tready <= 1'b0;
            out_stall     <= out_stall - 1;
        end else if (stall_enable && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            out_stall     <= $urandom_range(0, 7);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic drain();
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_orphan_bodies();
        send_body(1'b0, rand_body(2));
        send_body(1'b0, rand_body(2));
    endtask

    task automatic test_extremes();
        body_t b;
        b = '{vz: {1'b1, {COORD_WIDTH-1{1'b0}}}, vy: {1'b0, {COORD_WIDTH-1{1'b1}}},
              vx: '1, pz: '0, py: {1'b1, {COORD_WIDTH-1{1'b0}}},
              px: {1'b0, {COORD_WIDTH-1{1'b1}}}, mass: '1};
        send_body(1'b1, b);
        send_body(1'b0, b);
        send_body(1'b0, b);
        b.px = '1; b.py = '0; b.vz = {1'b0, {COORD_WIDTH-1{1'b1}}};
        send_body(1'b0, b);
        send_body(1'b1, '{default: '0});
        send_body(1'b0, b);
        b.mass = MASS_WIDTH'(1);
        send_body(1'b1, b);
        b.mass = '1;
        send_body(1'b0, b);
        send_body(1'b0, rand_body(0));
        drain();
    endtask

    task automatic test_small_systems();
        body_t b;
        b = rand_body(2);
        b.mass = MASS_WIDTH'(64'd1 << 44);
        send_body(1'b1, b);
        for (int i = 0; i < 4; i++) send_body(1'b0, rand_body(2));
        drain();
    endtask

    task automatic test_random_systems(int n_items, bit stalls);
        int sent;
        int mode;
        stall_enable = stalls;
        sent = 0;
        while (sent < n_items) begin
            mode = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
            send_body($urandom_range(0, 24) != 0, rand_body(mode)) ;
            sent++;
            for (int k = $urandom_range(1, 6); k > 0 && sent < n_items; k--) begin
                send_body($urandom_range(0, 29) == 0, rand_body(mode));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_orphan_bodies();
        test_extremes();
        test_small_systems();
        test_random_systems(700, 1'b1);
        drain();
        test_random_systems(150, 1'b0);
        drain();
        repeat (1000) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
